>>> hdl/hcbp_pkg.sv
package hcbp_pkg;

    localparam int SYMBOLS_DEF      = 256;
    localparam int MAX_CODE_LEN_DEF = 29;

    localparam int FUNC_W   = 2;
    localparam int SYM_W    = 8;
    localparam int WORD_W   = 29;
    localparam int LEN_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int TOTAL_W  = 32;
    localparam int PEND_W   = 3;

    // pending bits (up to 7) plus the longest code (up to 31), rounded to whole bytes
    localparam int ACC_W    = 40;
    localparam int ACC_SH_W = $clog2(ACC_W + 1);
    localparam int SUM_W    = 6;
    localparam int MAX_BYTES = 4;
    localparam int CNT_W    = $clog2(MAX_BYTES + 1);
    localparam int IDX_W    = $clog2(MAX_BYTES);

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENCODE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                 count;
        logic [TOTAL_W-1:0]               total;
    } res_group_t;

endpackage

>>> hdl/hcbp_ifs.sv
interface hcbp_in_if;
    import hcbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;
    logic [WORD_W-1:0] code_word;
    logic [LEN_W-1:0]  code_len;

    modport source (output valid, output func, output symbol, output code_word,
                    output code_len, input ready);
    modport sink   (input valid, input func, input symbol, input code_word,
                    input code_len, output ready);
endinterface

interface hcbp_out_if;
    import hcbp_pkg::*;

    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic               last;
    logic [TOTAL_W-1:0] total_bits;

    modport source (output valid, output out_byte, output last, output total_bits,
                    input ready);
    modport sink   (input valid, input out_byte, input last, input total_bits,
                    output ready);
endinterface

>>> hdl/hcbp_ram.sv
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/hcbp_code_table.sv
module hcbp_code_table #(
    parameter int SYMBOLS      = hcbp_pkg::SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic                         rd_en,
    input  logic [hcbp_pkg::SYM_W-1:0]   symbol,
    input  logic [hcbp_pkg::WORD_W-1:0]  wr_word,
    input  logic [hcbp_pkg::LEN_W-1:0]   wr_len,
    output logic [hcbp_pkg::WORD_W-1:0]  rd_word,
    output logic [hcbp_pkg::LEN_W-1:0]   rd_len
);
    import hcbp_pkg::*;

    localparam int AW      = $clog2(SYMBOLS);
    localparam int ENTRY_W = WORD_W + LEN_W;

    logic               in_range;
    logic [AW-1:0]      addr;
    logic [LEN_W-1:0]   len_clamp;
    logic               we;
    logic [ENTRY_W-1:0] rdata;
    logic [SYMBOLS-1:0] vld_reg;
    logic               hit_reg;

    assign in_range  = 32'(symbol) < SYMBOLS;
    assign addr      = symbol[AW-1:0];
    assign len_clamp = (32'(wr_len) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : wr_len;
    assign we        = wr_en && in_range;

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOLS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (addr),
        .wdata ({len_clamp, wr_word}),
        .re    (rd_en),
        .raddr (addr),
        .rdata (rdata)
    );

    // entries never loaded since reset read as absent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= in_range && vld_reg[addr];
            end
        end
    end

    assign rd_word = hit_reg ? rdata[WORD_W-1:0] : '0;
    assign rd_len  = hit_reg ? rdata[ENTRY_W-1:WORD_W] : '0;

endmodule

>>> hdl/hcbp_packer.sv
module hcbp_packer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic [hcbp_pkg::FUNC_W-1:0]  take_func,
    input  logic [hcbp_pkg::WORD_W-1:0]  code_word,
    input  logic [hcbp_pkg::LEN_W-1:0]   code_len,
    input  logic                         res_free,
    output logic                         ready,
    output logic                         grp_load,
    output hcbp_pkg::res_group_t         grp
);
    import hcbp_pkg::*;

    logic                s1_valid_reg, s1_valid_next;
    logic                s1_flush_reg;
    logic [PEND_W-1:0]   pend_cnt_reg, pend_cnt_next;
    logic [BYTE_W-1:0]   pend_byte_reg, pend_byte_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;

    logic [WORD_W-1:0]   code_mask;
    logic [WORD_W-1:0]   code_bits;
    logic [ACC_W-1:0]    acc;
    logic [ACC_W-1:0]    aligned;
    logic [SUM_W-1:0]    sum_bits;
    logic [ACC_SH_W-1:0] align_sh;
    logic [PEND_W-1:0]   rem;
    logic [CNT_W-1:0]    nbytes;
    logic [BYTE_W-1:0]   rem_mask;
    logic [TOTAL_W:0]    total_sum;
    logic [BYTE_W-1:0]   flush_byte;
    logic                has_out;
    logic                adv;

    assign code_mask = WORD_W'((64'd1 << code_len) - 64'd1);
    assign code_bits = code_word & code_mask;
    assign acc       = (ACC_W'(pend_byte_reg) << code_len) | ACC_W'(code_bits);
    assign sum_bits  = SUM_W'(pend_cnt_reg) + SUM_W'(code_len);
    assign align_sh  = ACC_SH_W'(ACC_W) - ACC_SH_W'(sum_bits);
    assign aligned   = acc << align_sh;
    assign nbytes    = CNT_W'(sum_bits >> 3);
    assign rem       = sum_bits[PEND_W-1:0];
    assign rem_mask  = BYTE_W'((9'd1 << rem) - 9'd1);
    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(code_len);
    assign flush_byte = pend_byte_reg << (4'(BYTE_W) - 4'(pend_cnt_reg));

    always_comb
    begin
        for (int k = 0; k < MAX_BYTES; k++)
        begin
            if (s1_flush_reg)
            begin
                grp.bytes[k] = (k == 0) ? flush_byte : '0;
            end
            else
            begin
                grp.bytes[k] = aligned[ACC_W-1-BYTE_W*k -: BYTE_W];
            end
        end
        grp.count = s1_flush_reg ? CNT_W'(1) : nbytes;
        grp.total = s1_flush_reg ? total_reg : '0;
    end

    assign has_out  = s1_flush_reg || (nbytes != '0);
    assign adv      = s1_valid_reg && (!has_out || res_free);
    assign ready    = !s1_valid_reg || adv;
    assign grp_load = adv && has_out;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        pend_cnt_next  = pend_cnt_reg;
        pend_byte_next = pend_byte_reg;
        total_next     = total_reg;
        if (adv)
        begin
            s1_valid_next = 1'b0;
            if (s1_flush_reg)
            begin
                pend_cnt_next  = '0;
                pend_byte_next = '0;
            end
            else
            begin
                pend_cnt_next  = rem;
                pend_byte_next = acc[BYTE_W-1:0] & rem_mask;
                total_next     = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
            end
        end
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pend_cnt_reg  <= '0;
            pend_byte_reg <= '0;
            total_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            pend_cnt_reg  <= pend_cnt_next;
            pend_byte_reg <= pend_byte_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_flush_reg <= (take_func == FUNC_FLUSH);
        end
    end

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv) |=> s1_valid_reg)
        else $error("stalled request dropped from stage one");

    a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_byte_reg >> pend_cnt_reg) == '0)
        else $error("pending byte holds bits above its count");

    a_grp_count: assert property (@(posedge clk) disable iff (!rst_n)
        grp_load |-> (grp.count != '0 && grp.count <= CNT_W'(MAX_BYTES)))
        else $error("result group byte count out of range");
`endif

endmodule

>>> hdl/hcbp_out_buf.sv
module hcbp_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 grp_load,
    input  hcbp_pkg::res_group_t grp,
    output logic                 res_free,
    hcbp_out_if.source           res
);
    import hcbp_pkg::*;

    logic             res_valid_reg;
    res_group_t       res_grp_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic             is_last;
    logic             take_out;

    assign is_last  = ({1'b0, res_idx_reg} == res_grp_reg.count - CNT_W'(1));
    assign take_out = res_valid_reg && res.ready;
    assign res_free = !res_valid_reg || (take_out && is_last);

    assign res.valid      = res_valid_reg;
    assign res.out_byte   = res_grp_reg.bytes[res_idx_reg];
    assign res.last       = is_last;
    assign res.total_bits = res_grp_reg.total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_idx_reg   <= '0;
        end
        else if (grp_load)
        begin
            res_valid_reg <= 1'b1;
            res_idx_reg   <= '0;
        end
        else if (take_out)
        begin
            if (is_last)
            begin
                res_valid_reg <= 1'b0;
            end
            else
            begin
                res_idx_reg <= res_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_load)
        begin
            res_grp_reg <= grp;
        end
    end

`ifndef SYNTH
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ({1'b0, res_idx_reg} < res_grp_reg.count))
        else $error("byte index beyond result group");
`endif

endmodule

>>> hdl/huffman_code_bit_packer_unit.sv
// Huffman code bit packer. Load requests write a symbol's code word and length
// into a code table held in a registered RAM with one write and one read port
// and a valid bit per entry, so the table reads as empty right after reset
// with no clearing pass. Encode requests look the symbol up and append its
// code bits MSB first to a byte accumulator; flush requests pad and emit the
// partial byte with the saturating bit total. One request is accepted per
// cycle while the packer stage is not stalled; a request that produces k bytes
// (encode 0 to 4, flush 1) holds the single result register until its bytes
// have left, one per cycle while the receiver is ready. The first byte passes
// the table read register and the packer stage into the result register.
module huffman_code_bit_packer_unit #(
    parameter int SYMBOLS      = hcbp_pkg::SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hcbp_in_if.sink    req,
    hcbp_out_if.source res
);
    import hcbp_pkg::*;

    logic              accept;
    logic              pk_ready;
    logic              take;
    logic              grp_load;
    logic              res_free;
    res_group_t        grp;
    logic [WORD_W-1:0] rd_word;
    logic [LEN_W-1:0]  rd_len;

    assign req.ready = pk_ready;
    assign accept    = req.valid && pk_ready;
    assign take      = accept && (req.func == FUNC_ENCODE || req.func == FUNC_FLUSH);

    hcbp_code_table #(
        .SYMBOLS      (SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && req.func == FUNC_LOAD),
        .rd_en   (accept && req.func == FUNC_ENCODE),
        .symbol  (req.symbol),
        .wr_word (req.code_word),
        .wr_len  (req.code_len),
        .rd_word (rd_word),
        .rd_len  (rd_len)
    );

    hcbp_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .take_func (req.func),
        .code_word (rd_word),
        .code_len  (rd_len),
        .res_free  (res_free),
        .ready     (pk_ready),
        .grp_load  (grp_load),
        .grp       (grp)
    );

    hcbp_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .grp_load (grp_load),
        .grp      (grp),
        .res_free (res_free),
        .res      (res)
    );

endmodule

>>> bench/huffman_code_bit_packer_unit_tb.sv
`timescale 1ns / 100ps

module huffman_code_bit_packer_unit_tb;
    import hcbp_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 33;
    localparam int POOL_SIZE    = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int N_DIRECTED   = 24;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } packed_byte_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [SYM_W-1:0]   symbol;
        logic [WORD_W-1:0]  word;
        logic [LEN_W-1:0]   len;
        logic               typed;
        logic               has_result;
        logic [BYTE_W-1:0]  data;
        logic [TOTAL_W-1:0] total;
    } stim_row_t;

    logic clk;
    logic rst_n;

    hcbp_in_if  req_if ();
    hcbp_out_if res_if ();

    huffman_code_bit_packer_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if)
    );

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{FUNC_FLUSH,  8'd0,   29'h0000_0000, 5'd0,  1'b1, 1'b1, 8'h00, 32'd0},
        '{FUNC_ENCODE, 8'd0,   29'h0000_0000, 5'd0,  1'b1, 1'b0, 8'h00, 32'd0},
        '{FUNC_UNUSED, 8'd255, 29'h1FFF_FFFF, 5'd31, 1'b1, 1'b0, 8'h00, 32'd0},
        '{FUNC_LOAD,   8'd0,   29'h1FFF_FFFF, 5'd31, 1'b1, 1'b0, 8'h00, 32'd0},
        '{FUNC_LOAD,   8'd255, 29'h0000_0000, 5'd1,  1'b1, 1'b0, 8'h00, 32'd0},
        '{FUNC_LOAD,   8'd1,   29'h0000_0005, 5'd3,  1'b1, 1'b0, 8'h00, 32'd0},
        '{FUNC_LOAD,   8'd2,   29'h0AAA_AAAA, 5'd29, 1'b1, 1'b0, 8'h00, 32'd0},
        '{FUNC_ENCODE, 8'd0,   29'h0000_0000, 5'd0,  1'b0, 1'b0, 8'h00, 32'd0},
        '{FUNC_ENCODE, 8'd255, 29'h1FFF_FFFF, 5'd31, 1'b0, 1'b0, 8'h00, 32'd0},
        '{FUNC_ENCODE, 8'd1,   29'h0000_0000, 5'd0,  1'b0, 1'b0, 8'h00, 32'd0},
        '{FUNC_FLUSH,  8'd0,   29'h0000_0000, 5'd0,  1'b0, 1'b0, 8'h00, 32'd0},
        '{FUNC_FLUSH,  8'd255, 29'h1FFF_FFFF, 5'd31, 1'b0, 1'b0, 8'h00, 32'd0},
        '{FUNC_LOAD,   8'd3,   29'h1FFF_FFFF, 5'd0,  1'b1, 1'b0, 8'h00, 32'd0},
        '{FUNC_ENCODE, 8'd3,   29'h0000_0000, 5'd0,  1'b0, 1'b0, 8'h00, 32'd0},
        '{FUNC_LOAD,   8'd4,   29'h0000_00A5, 5'd8,  1'b1, 1'b0, 8'h00, 32'd0},
        '{FUNC_ENCODE, 8'd4,   29'h0000_0000, 5'd0,  1'b1, 1'b1, 8'hA5, 32'd0},
        '{FUNC_LOAD,   8'd5,   29'h1555_5555, 5'd30, 1'b1, 1'b0, 8'h00, 32'd0},
        '{FUNC_ENCODE, 8'd2,   29'h0000_0000, 5'd0,  1'b0, 1'b0, 8'h00, 32'd0},
        '{FUNC_ENCODE, 8'd5,   29'h0000_0000, 5'd0,  1'b0, 1'b0, 8'h00, 32'd0},
        '{FUNC_ENCODE, 8'd0,   29'h0000_0000, 5'd0,  1'b0, 1'b0, 8'h00, 32'd0},
        '{FUNC_FLUSH,  8'd0,   29'h0000_0000, 5'd0,  1'b0, 1'b0, 8'h00, 32'd0},
        '{FUNC_LOAD,   8'd128, 29'h1000_0000, 5'd29, 1'b1, 1'b0, 8'h00, 32'd0},
        '{FUNC_ENCODE, 8'd128, 29'h0000_0000, 5'd0,  1'b0, 1'b0, 8'h00, 32'd0},
        '{FUNC_FLUSH,  8'd0,   29'h0000_0000, 5'd0,  1'b0, 1'b0, 8'h00, 32'd0}
    };

    logic [WORD_W-1:0]  tbl_word [SYMBOLS_DEF];
    logic [LEN_W-1:0]   tbl_len  [SYMBOLS_DEF];
    logic [BYTE_W-1:0]  acc_byte;
    int                 acc_cnt;
    logic [TOTAL_W-1:0] bit_total;
    packed_byte_t       packed_out [MAX_BYTES];
    packed_byte_t       bytes_due [$];
    logic [SYM_W-1:0]   pool [POOL_SIZE];

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_arm;
    bit hold_done;
    int hold_left;
    int n_fail;
    int cycles;

    function automatic int pack_codes(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s,
                                      input logic [WORD_W-1:0] w, input logic [LEN_W-1:0] l);
        int                 n;
        int                 i;
        logic [WORD_W-1:0]  cw;
        logic [LEN_W-1:0]   cl;
        logic [TOTAL_W:0]   sum;
        logic [BYTE_W-1:0]  flushed;
        n = 0;
        case (f)
            FUNC_LOAD:
            begin
                tbl_word[s] = w;
                tbl_len[s]  = (l > MAX_CODE_LEN_DEF) ? LEN_W'(MAX_CODE_LEN_DEF) : l;
            end
            FUNC_ENCODE:
            begin
                cw = tbl_word[s];
                cl = tbl_len[s];
                for (i = cl; i > 0; i--)
                begin
                    acc_byte = {acc_byte[BYTE_W-2:0], cw[i-1]};
                    acc_cnt++;
                    if (acc_cnt == BYTE_W)
                    begin
                        packed_out[n] = '{acc_byte, 1'b0, '0};
                        n++;
                        acc_byte = '0;
                        acc_cnt  = 0;
                    end
                end
                sum = {1'b0, bit_total} + cl;
                bit_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                if (n > 0)
                    packed_out[n-1].last = 1'b1;
            end
            FUNC_FLUSH:
            begin
                flushed = (acc_cnt > 0) ? acc_byte << (BYTE_W - acc_cnt) : '0;
                packed_out[0] = '{flushed, 1'b1, bit_total};
                n = 1;
                acc_byte = '0;
                acc_cnt  = 0;
            end
            default:
            begin
            end
        endcase
        return n;
    endfunction

    task automatic queue_expected(input int n);
        int k;
        for (k = 0; k < n; k++)
            bytes_due.push_back(packed_out[k]);
    endtask

    task automatic send_req(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s,
                            input logic [WORD_W-1:0] w, input logic [LEN_W-1:0] l);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.func      <= f;
        req_if.symbol    <= s;
        req_if.code_word <= w;
        req_if.code_len  <= l;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
    endtask

    task automatic issue(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s,
                         input logic [WORD_W-1:0] w, input logic [LEN_W-1:0] l);
        send_req(f, s, w, l);
        queue_expected(pack_codes(f, s, w, l));
    endtask

    function automatic logic [LEN_W-1:0] rand_code_len();
        if ($urandom_range(7) == 0)
            return LEN_W'($urandom_range(31));
        return LEN_W'($urandom_range(12, 1));
    endfunction

    task automatic send_random(output bit counted);
        int                pick;
        logic [SYM_W-1:0]  s;
        logic [WORD_W-1:0] w;
        logic [LEN_W-1:0]  l;
        pick    = $urandom_range(99);
        s       = pool[$urandom_range(POOL_SIZE-1)];
        w       = WORD_W'($urandom);
        l       = rand_code_len();
        counted = 1'b1;
        if (pick < 70)
            issue(FUNC_ENCODE, s, w, l);
        else if (pick < 78)
            issue(FUNC_LOAD, s, w, l);
        else if (pick < 88)
            issue(FUNC_FLUSH, s, w, l);
        else if (pick < 93)
            issue(FUNC_ENCODE, SYM_W'($urandom), w, l);
        else if (pick < 97)
            issue(FUNC_LOAD, SYM_W'($urandom), w, l);
        else
        begin
            issue(FUNC_UNUSED, SYM_W'($urandom), w, l);
            counted = 1'b0;
        end
    endtask

    task automatic wait_results();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (bytes_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_byte();
        packed_byte_t want;
        if (bytes_due.size() == 0)
        begin
            $error("out_byte: expected none, got %02h", res_if.out_byte);
            n_fail++;
        end
        else
        begin
            want = bytes_due.pop_front();
            if (res_if.out_byte !== want.data)
            begin
                $error("out_byte: expected %02h, got %02h", want.data, res_if.out_byte);
                n_fail++;
            end
            if (res_if.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, res_if.last);
                n_fail++;
            end
            if (res_if.total_bits !== want.total)
            begin
                $error("total_bits: expected %0d, got %0d", want.total, res_if.total_bits);
                n_fail++;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("huffman_code_bit_packer_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
                check_byte();
            // hold the receiver so the block backs up and stalls its input
            if (hold_left > 0)
                hold_left--;
            else if (hold_arm && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        int        k;
        int        phase;
        int        n_sent;
        bit        counted;
        stim_row_t row;
        req_if.valid     <= 1'b0;
        req_if.func      <= FUNC_LOAD;
        req_if.symbol    <= '0;
        req_if.code_word <= '0;
        req_if.code_len  <= '0;
        for (k = 0; k < SYMBOLS_DEF; k++)
        begin
            tbl_word[k] = '0;
            tbl_len[k]  = '0;
        end
        acc_byte    = '0;
        acc_cnt     = 0;
        bit_total   = '0;
        n_fail      = 0;
        hold_arm    = 1'b0;
        hold_done   = 1'b0;
        hold_left   = 0;
        tx_idle_pct = 34;
        rx_idle_pct = 51;
        wait (rst_n === 1'b1);
        @(posedge clk);

        for (k = 0; k < N_DIRECTED; k++)
        begin
            row = directed_rows[k];
            send_req(row.func, row.symbol, row.word, row.len);
            if (row.typed)
            begin
                void'(pack_codes(row.func, row.symbol, row.word, row.len));
                if (row.has_result)
                    bytes_due.push_back('{row.data, 1'b1, row.total});
            end
            else
                queue_expected(pack_codes(row.func, row.symbol, row.word, row.len));
        end
        wait_results();

        for (k = 0; k < POOL_SIZE; k++)
        begin
            pool[k] = SYM_W'($urandom);
            issue(FUNC_LOAD, pool[k], WORD_W'($urandom), rand_code_len());
        end

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 34;
                    rx_idle_pct = 51;
                end
                1:
                begin
                    tx_idle_pct = 51;
                    rx_idle_pct = 34;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_arm    = 1'b1;
                end
            endcase
            n_sent = 0;
            while (n_sent < PHASE_ITEMS)
            begin
                send_random(counted);
                n_sent += counted;
            end
            wait_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bytes_due.size() != 0)
        begin
            $error("out_byte: %0d bytes never arrived", bytes_due.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("huffman_code_bit_packer_unit_tb: done, clean");
        else
            $display("huffman_code_bit_packer_unit_tb: done, errors");
        $finish;
    end

endmodule

>>> huffman_code_bit_packer_unit.f
hdl/hcbp_pkg.sv
hdl/hcbp_ifs.sv
hdl/hcbp_ram.sv
hdl/hcbp_code_table.sv
hdl/hcbp_packer.sv
hdl/hcbp_out_buf.sv
hdl/huffman_code_bit_packer_unit.sv
bench/huffman_code_bit_packer_unit_tb.sv
